// ===== hw/rtl/mlfd_pkg.sv =====
// mlfd_pkg: sizes, table geometry, state encoding and the control/status
// structs shared by the learning-bridge forwarding block.
// No dependencies.
package mlfd_pkg;

  // Port and address widths
  localparam int MAC_W   = 48;
  localparam int PORT_W  = 3;
  localparam int MASK_W  = 8;
  localparam int APC_W   = 4;
  localparam int NUM_PORTS = 8;

  // Station table: TABLE_ENTRIES must be a multiple of LANES
  localparam int TABLE_ENTRIES = 64;
  localparam int LANES   = 8;
  localparam int LANE_W  = $clog2(LANES);
  localparam int ROWS    = TABLE_ENTRIES / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W   = ROW_W + LANE_W;
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [APC_W-1:0]  APC_RESET      = APC_W'(8);
  localparam logic [APC_W-1:0]  APC_MAX        = APC_W'(NUM_PORTS);
  localparam logic [MASK_W-1:0] ALL_PORTS_MASK = MASK_W'((1 << NUM_PORTS) - 1);

  // One table entry: station address and the port it was seen on
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic start;   // capture input word, clear search results
    logic rd_en;   // read next table row
    logic update;  // write table, load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;  // row being read is the last one
    logic out_free;   // result register can take a word this cycle
  } sts_t;

endpackage

// ===== hw/rtl/mlfd_in_if.sv =====
// mlfd_in_if: valid/ready channel carrying one frame's addresses and port.
// Depends on mlfd_pkg.
interface mlfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [mlfd_pkg::MAC_W-1:0]    src_mac;
  logic [mlfd_pkg::MAC_W-1:0]    dst_mac;
  logic [mlfd_pkg::PORT_W-1:0]   ingress_port;

  modport source (output valid, src_mac, dst_mac, ingress_port, input ready);
  modport sink   (input valid, src_mac, dst_mac, ingress_port, output ready);
endinterface

// ===== hw/rtl/mlfd_out_if.sv =====
// mlfd_out_if: valid/ready channel carrying one forwarding decision.
// Depends on mlfd_pkg.
interface mlfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [mlfd_pkg::MASK_W-1:0]   egress_mask;
  logic                          flooded;
  logic                          learn_dropped;

  modport source (output valid, egress_mask, flooded, learn_dropped, input ready);
  modport sink   (input valid, egress_mask, flooded, learn_dropped, output ready);
endinterface

// ===== hw/rtl/mlfd_ctrl.sv =====
// mlfd_ctrl: sequencer for accept, table scan, table update and result load.
// Depends on mlfd_pkg.
module mlfd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mlfd_pkg::sts_t   sts,
  output mlfd_pkg::cmd_t   cmd
);

  mlfd_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlfd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mlfd_pkg::ST_SCAN;
      end
      mlfd_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = mlfd_pkg::ST_DRAIN;
      end
      mlfd_pkg::ST_DRAIN: begin
        state_nxt = mlfd_pkg::ST_UPDATE;
      end
      mlfd_pkg::ST_UPDATE: begin
        if (sts.out_free) state_nxt = mlfd_pkg::ST_IDLE;
      end
      default: state_nxt = mlfd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      mlfd_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      mlfd_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      mlfd_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      mlfd_pkg::ST_UPDATE: begin
        cmd.update = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/mlfd_dp.sv =====
// mlfd_dp: station table (row-wide memory, LANES entries per row), lane
// comparators, fill count, port-count register and result register.
// Depends on mlfd_pkg.
module mlfd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlfd_pkg::cmd_t                cmd,
  output mlfd_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [mlfd_pkg::APC_W-1:0]    cfg_wdata,
  input  logic [mlfd_pkg::MAC_W-1:0]    in_src_mac,
  input  logic [mlfd_pkg::MAC_W-1:0]    in_dst_mac,
  input  logic [mlfd_pkg::PORT_W-1:0]   in_ingress_port,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mlfd_pkg::MASK_W-1:0]   out_egress_mask,
  output logic                          out_flooded,
  output logic                          out_learn_dropped
);

  // Table memory: one row holds LANES entries, written one entry at a time
  mlfd_pkg::entry_t [mlfd_pkg::LANES-1:0] mem [mlfd_pkg::ROWS];

  logic [mlfd_pkg::APC_W-1:0]  apc_r;
  logic [mlfd_pkg::CNT_W-1:0]  fill_r;
  logic [mlfd_pkg::MAC_W-1:0]  src_r, dst_r;
  logic [mlfd_pkg::PORT_W-1:0] ingress_r;
  logic [mlfd_pkg::ROW_W-1:0]  rd_row_r, cmp_row_r;
  logic                        cmp_vld_r;
  mlfd_pkg::entry_t [mlfd_pkg::LANES-1:0] rd_data_r;

  logic                        src_hit_r, dst_hit_r;
  logic [mlfd_pkg::ROW_W-1:0]  src_row_r;
  logic [mlfd_pkg::LANE_W-1:0] src_lane_r;
  logic [mlfd_pkg::PORT_W-1:0] dst_port_r;

  logic                        out_valid_r, out_flooded_r, out_dropped_r;
  logic [mlfd_pkg::MASK_W-1:0] out_mask_r;

  // Status
  assign sts.scan_last = (rd_row_r == mlfd_pkg::ROW_W'(mlfd_pkg::ROWS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Port-count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apc_r <= mlfd_pkg::APC_RESET;
    end else if (cfg_we) begin
      apc_r <= cfg_wdata;
    end
  end

  // Input word capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src_r     <= in_src_mac;
      dst_r     <= in_dst_mac;
      ingress_r <= in_ingress_port;
    end
  end

  // Row read pointer and registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_row_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_en;
      if (cmd.start) begin
        rd_row_r <= '0;
      end else if (cmd.rd_en) begin
        rd_row_r <= rd_row_r + mlfd_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_row_r];
      cmp_row_r <= rd_row_r;
    end
  end

  // Lane compare: entries at index below the fill count are valid
  logic                        src_any, dst_any;
  logic [mlfd_pkg::LANE_W-1:0] src_lane;
  logic [mlfd_pkg::PORT_W-1:0] dst_port;

  always_comb begin
    logic [mlfd_pkg::CNT_W-1:0] idx;
    logic                       ent_vld;
    src_any  = 1'b0;
    dst_any  = 1'b0;
    src_lane = '0;
    dst_port = '0;
    for (int l = mlfd_pkg::LANES - 1; l >= 0; l--) begin
      idx     = {1'b0, cmp_row_r, mlfd_pkg::LANE_W'(l)};
      ent_vld = (idx < fill_r);
      if (ent_vld && (rd_data_r[l].mac == src_r)) begin
        src_any  = 1'b1;
        src_lane = mlfd_pkg::LANE_W'(l);
      end
      if (ent_vld && (rd_data_r[l].mac == dst_r)) begin
        dst_any  = 1'b1;
        dst_port = rd_data_r[l].port;
      end
    end
  end

  // Search results
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src_hit_r <= 1'b0;
      dst_hit_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (src_any) begin
        src_hit_r  <= 1'b1;
        src_row_r  <= cmp_row_r;
        src_lane_r <= src_lane;
      end
      if (dst_any) begin
        dst_hit_r  <= 1'b1;
        dst_port_r <= dst_port;
      end
    end
  end

  // Learn: update a known station, or append at the fill count unless the table is full
  logic full;
  assign full = (fill_r == mlfd_pkg::CNT_W'(mlfd_pkg::TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.update && !src_hit_r && !full) begin
      fill_r <= fill_r + mlfd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (src_hit_r) begin
        mem[src_row_r][src_lane_r] <= '{mac: src_r, port: ingress_r};
      end else if (!full) begin
        mem[fill_r[mlfd_pkg::IDX_W-1:mlfd_pkg::LANE_W]][fill_r[mlfd_pkg::LANE_W-1:0]]
          <= '{mac: src_r, port: ingress_r};
      end
    end
  end

  // Forwarding decision; destination equal to source follows the learn step
  logic                        dropped, fwd_hit;
  logic [mlfd_pkg::PORT_W-1:0] fwd_port;
  logic [mlfd_pkg::APC_W-1:0]  apc_clamp;
  logic [mlfd_pkg::MASK_W-1:0] flood_mask, fwd_mask;

  assign dropped   = !src_hit_r && full;
  assign apc_clamp = (apc_r > mlfd_pkg::APC_MAX) ? mlfd_pkg::APC_MAX : apc_r;

  always_comb begin
    if (dst_r == src_r) begin
      fwd_hit  = !dropped;
      fwd_port = ingress_r;
    end else begin
      fwd_hit  = dst_hit_r;
      fwd_port = dst_port_r;
    end
  end

  always_comb begin
    for (int j = 0; j < mlfd_pkg::MASK_W; j++) begin
      flood_mask[j] = (mlfd_pkg::APC_W'(j) < apc_clamp) &&
                      (mlfd_pkg::PORT_W'(j) != ingress_r);
    end
  end

  assign fwd_mask = fwd_hit ? ((mlfd_pkg::MASK_W'(1) << fwd_port) & mlfd_pkg::ALL_PORTS_MASK)
                            : flood_mask;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_mask_r    <= fwd_mask;
      out_flooded_r <= !fwd_hit;
      out_dropped_r <= dropped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_egress_mask   = out_mask_r;
  assign out_flooded       = out_flooded_r;
  assign out_learn_dropped = out_dropped_r;

endmodule

// ===== hw/rtl/mac_learning_forward_decision.sv =====
// mac_learning_forward_decision: top level of the learning-bridge forwarding block.
// Depends on mlfd_pkg, mlfd_in_if, mlfd_out_if, mlfd_ctrl, mlfd_dp.
//
//  channel   dir  handshake        payload
//  in_if     in   valid/ready      src_mac[47:0] dst_mac[47:0] ingress_port[2:0]
//  out_if    out  valid/ready      egress_mask[7:0] flooded learn_dropped
//  cfg       in   cfg_we           cfg_wdata[3:0] -> active_port_count
//
// A word passes through accept, a scan of the table rows of LANES entries each
// via the single memory read port, a compare of the last row, and an update
// that waits for a free result register. The result register lets the next
// word be accepted while a decision waits on out_if. Reset (rst_n, synchronous)
// empties the table at once through its fill count; no clearing pass.
module mac_learning_forward_decision (
  input  logic                       clk,
  input  logic                       rst_n,
  mlfd_in_if.sink                    in_if,
  mlfd_out_if.source                 out_if,
  input  logic                       cfg_we,
  input  logic [mlfd_pkg::APC_W-1:0] cfg_wdata
);

  mlfd_pkg::cmd_t cmd;
  mlfd_pkg::sts_t sts;

  // Sequencer
  mlfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table and decision datapath
  mlfd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_src_mac        (in_if.src_mac),
    .in_dst_mac        (in_if.dst_mac),
    .in_ingress_port   (in_if.ingress_port),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_egress_mask   (out_if.egress_mask),
    .out_flooded       (out_if.flooded),
    .out_learn_dropped (out_if.learn_dropped)
  );

`ifndef SYNTHESIS
  // Busy after accepting a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted twice in a row");

  // A table update always presents a decision next cycle
  a_update_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_if.valid)
    else $error("update without result");

  // A known destination goes to at most one port
  a_hit_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.flooded) |-> $countones(out_if.egress_mask) <= 1)
    else $error("hit mask not one-hot");

  // Update only while the controller is not ready to accept a word
  a_update_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !in_if.ready)
    else $error("update while idle");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for mac_learning_forward_decision, with its own
// station table predictor, random valid/ready idling and a scoreboard queue.
// Depends on mlfd_pkg, mlfd_in_if, mlfd_out_if and the block's RTL.
module tb;
  import mlfd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int POOL_SIZE    = 40;
  localparam int CHUNK_WORDS  = 110;

  typedef logic [MAC_W-1:0]  mac_t;
  typedef logic [PORT_W-1:0] port_t;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              learn_dropped;
  } decision_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [APC_W-1:0] cfg_wdata;

  mlfd_in_if  in_if();
  mlfd_out_if out_if();

  mac_learning_forward_decision u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted station table: entries fill from 0 up and are never removed
  mac_t             station_mac  [TABLE_ENTRIES];
  port_t            station_port [TABLE_ENTRIES];
  int               station_used;
  logic [APC_W-1:0] port_count;

  decision_t decision_q[$];
  mac_t      mac_pool[$];

  int errors, n_words, n_results, n_flooded, n_hits, n_dropped, cycles;
  bit no_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic mac_t rand_mac();
    return mac_t'({$urandom(), $urandom()});
  endfunction

  function automatic int find_station(mac_t mac);
    for (int i = 0; i < station_used; i++)
      if (station_mac[i] == mac) return i;
    return -1;
  endfunction

  // Learn the source, then look up the destination in the updated table
  function automatic decision_t forward_frame(mac_t src, mac_t dst, port_t ingress);
    decision_t d;
    int        idx;
    int        cnt;
    d = '0;
    idx = find_station(src);
    if (idx >= 0) begin
      station_port[idx] = ingress;
    end else if (station_used < TABLE_ENTRIES) begin
      station_mac[station_used]  = src;
      station_port[station_used] = ingress;
      station_used++;
    end else begin
      d.learn_dropped = 1'b1;
    end
    idx = find_station(dst);
    if (idx >= 0) begin
      d.egress_mask = ALL_PORTS_MASK & (MASK_W'(1) << station_port[idx]);
    end else begin
      // counts above the port total clamp to it
      cnt = (port_count > APC_MAX) ? NUM_PORTS : int'(port_count);
      for (int j = 0; j < cnt; j++)
        if (j != int'(ingress)) d.egress_mask[j] = 1'b1;
      d.flooded = 1'b1;
    end
    return d;
  endfunction

  // Offer one word, optionally after a random gap, and log its decision
  task automatic send_frame(mac_t src, mac_t dst, port_t ingress);
    if (!no_idle && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.src_mac      <= src;
    in_if.dst_mac      <= dst;
    in_if.ingress_port <= ingress;
    do @(posedge clk); while (!in_if.ready);
    decision_q.push_back(forward_frame(src, dst, ingress));
    n_words++;
  endtask

  // Stop sending and wait for every pending decision
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_port_count(logic [APC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    port_count  = value;
  endtask

  // Empty table: self-addressed frames, address extremes, port moves
  task automatic test_basic_forwarding();
    mac_t a;
    mac_t r;
    a = 48'h0123_4567_89AB;
    r = rand_mac();
    send_frame('0, '0, 3'd0);
    send_frame('1, 48'h0000_0000_0001, 3'd7);
    send_frame(a, '1, 3'd3);
    send_frame('1, a, 3'd2);
    send_frame(a, '1, 3'd5);
    send_frame(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 3'd6);
    send_frame(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 3'd1);
    send_frame(r, r, 3'd4);
    wait_idle();
  endtask

  // Flood masks over the count extremes, ingress inside and outside range
  task automatic test_port_count();
    logic [APC_W-1:0] counts [6];
    counts = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd9, 4'd15};
    foreach (counts[k]) begin
      write_port_count(counts[k]);
      send_frame('0, rand_mac(), 3'd0);
      send_frame('0, rand_mac(), 3'd7);
      // learned port above the active count is still sent to
      if (counts[k] == 4'd1) send_frame('0, '1, 3'd0);
      wait_idle();
    end
  endtask

  // Random traffic over a pool that fits in the table
  task automatic test_learned_traffic();
    mac_t src;
    mac_t dst;
    int   r;
    repeat (POOL_SIZE) mac_pool.push_back(rand_mac());
    for (int c = 0; c < 4; c++) begin
      write_port_count((c == 0) ? 4'd8 : 4'($urandom_range(15, 0)));
      repeat (CHUNK_WORDS) begin
        src = mac_pool[$urandom_range(POOL_SIZE - 1)];
        r   = $urandom_range(99);
        if (r < 65)      dst = mac_pool[$urandom_range(POOL_SIZE - 1)];
        else if (r < 80) dst = src;
        else             dst = rand_mac();
        send_frame(src, dst, 3'($urandom_range(7)));
      end
      wait_idle();
    end
  endtask

  // Fill the table with new sources, then overflow it
  task automatic test_table_full();
    mac_t src;
    write_port_count(4'd8);
    while (station_used < TABLE_ENTRIES)
      send_frame(rand_mac(), station_mac[$urandom_range(station_used - 1)],
                 3'($urandom_range(7)));
    for (int i = 0; i < 12; i++) begin
      src = rand_mac();
      // a dropped source addressed to itself misses and floods
      send_frame(src, i[0] ? src : station_mac[$urandom_range(TABLE_ENTRIES - 1)],
                 3'($urandom_range(7)));
    end
    wait_idle();
  endtask

  // Full table: known and unknown sources and destinations
  task automatic test_full_table_traffic();
    mac_t src;
    mac_t dst;
    int   r;
    for (int c = 0; c < 6; c++) begin
      write_port_count((c == 0) ? 4'd15 : (c == 1) ? 4'd0 : 4'($urandom_range(15, 0)));
      no_idle = (c == 2);
      repeat (CHUNK_WORDS) begin
        if ($urandom_range(1)) src = station_mac[$urandom_range(TABLE_ENTRIES - 1)];
        else                   src = rand_mac();
        r = $urandom_range(99);
        if (r < 55)      dst = station_mac[$urandom_range(TABLE_ENTRIES - 1)];
        else if (r < 70) dst = src;
        else             dst = rand_mac();
        send_frame(src, dst, 3'($urandom_range(7)));
      end
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, compare each accepted word with the oldest entry
  always @(posedge clk) begin : check_decisions
    decision_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= 17);
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (decision_q.size() == 0) begin
          $error("decision word with no frame pending");
          errors++;
        end else begin
          want = decision_q.pop_front();
          if (out_if.egress_mask !== want.egress_mask) begin
            $error("egress_mask: expected %h, got %h", want.egress_mask, out_if.egress_mask);
            errors++;
          end
          if (out_if.flooded !== want.flooded) begin
            $error("flooded: expected %b, got %b", want.flooded, out_if.flooded);
            errors++;
          end
          if (out_if.learn_dropped !== want.learn_dropped) begin
            $error("learn_dropped: expected %b, got %b", want.learn_dropped,
                   out_if.learn_dropped);
            errors++;
          end
          if (want.flooded) n_flooded++;
          else              n_hits++;
          if (want.learn_dropped) n_dropped++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d decisions outstanding", cycles,
               decision_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sequence
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.src_mac      = '0;
    in_if.dst_mac      = '0;
    in_if.ingress_port = '0;
    station_used       = 0;
    port_count         = APC_RESET;
    no_idle            = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_forwarding();
    test_port_count();
    test_learned_traffic();
    test_table_full();
    test_full_table_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d frames, checked %0d decisions in %0d cycles", n_words, n_results,
             cycles);
    $display("  %0d floods, %0d table hits, %0d learns dropped with %0d of %0d entries used",
             n_flooded, n_hits, n_dropped, station_used, TABLE_ENTRIES);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
